[rtl/core/wspid_pkg.sv]
// Shared widths, limits, register indexes and types for the wheel speed PID core.
// Used by the channel interfaces, the error stage and the top level.
package wspid_pkg;

    localparam int SPEED_W   = 16;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 17;
    localparam int INTEG_W   = 15;
    localparam int DRIVE_W   = 15;
    localparam int PROD_W    = 33;
    localparam int ACC_W     = 35;
    localparam int FRAC_BITS = 8;
    localparam int CFG_IDX_W = 2;

    localparam int INPUT_LIMIT    = 20000;
    localparam int TARGET_LIMIT   = 10000;
    localparam int INTEGRAL_LIMIT = 10000;
    localparam int OUTPUT_LIMIT   = 10000;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    typedef logic signed [SPEED_W-1:0] speed_t;
    typedef logic signed [GAIN_W-1:0]  gain_t;
    typedef logic signed [ERR_W-1:0]   err_t;
    typedef logic signed [INTEG_W-1:0] integ_t;
    typedef logic signed [DRIVE_W-1:0] drive_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Terms handed from the error stage to the multiply stage
    typedef struct packed {
        err_t   err;
        integ_t integral;
        err_t   deriv;
    } err_terms_t;

    // Symmetric saturation to +/-lim
    function automatic acc_t sat(input acc_t x, input int lim);
        acc_t hi;
        acc_t lo;
        hi = ACC_W'(lim);
        lo = -ACC_W'(lim);
        if (x > hi)
            return hi;
        else if (x < lo)
            return lo;
        else
            return x;
    endfunction

endpackage

[rtl/core/wspid_sample_if.sv]
// Input channel: measured and target wheel speed, valid/ready handshake.
// Depends on wspid_pkg for field types.
interface wspid_sample_if;
    logic             valid;
    logic             ready;
    wspid_pkg::speed_t measured;
    wspid_pkg::speed_t setpoint;

    modport source (output valid, output measured, output setpoint, input ready);
    modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

[rtl/core/wspid_result_if.sv]
// Output channel: saturated drive command, valid/ready handshake.
// Depends on wspid_pkg for the field type.
interface wspid_result_if;
    logic             valid;
    logic             ready;
    wspid_pkg::drive_t drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

[rtl/core/wspid_cfg_if.sv]
// Configuration write channel: register index and data, valid/ready handshake.
// Depends on wspid_pkg for widths.
interface wspid_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [wspid_pkg::CFG_IDX_W-1:0]     index;
    logic [wspid_pkg::GAIN_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/wspid_err_stage.sv]
// Error stage: clamps speeds, forms error, clamped integral and derivative.
// Holds the loop state (previous error, integral). Depends on wspid_pkg.
module wspid_err_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  wspid_pkg::speed_t       measured,
    input  wspid_pkg::speed_t       setpoint,
    output wspid_pkg::err_terms_t   terms
);

    wspid_pkg::err_t   prev_error_reg;
    wspid_pkg::err_t   prev_error_next;
    wspid_pkg::integ_t integral_reg;
    wspid_pkg::integ_t integral_next;
    wspid_pkg::err_t   deriv_reg;
    wspid_pkg::err_t   deriv_next;

    wspid_pkg::err_t   meas_c;
    wspid_pkg::err_t   targ_c;
    wspid_pkg::acc_t   integ_sum;

    always_comb
    begin
        meas_c = wspid_pkg::ERR_W'(wspid_pkg::sat(wspid_pkg::ACC_W'(measured),
                                                  wspid_pkg::INPUT_LIMIT));
        targ_c = wspid_pkg::ERR_W'(wspid_pkg::sat(wspid_pkg::ACC_W'(setpoint),
                                                  wspid_pkg::TARGET_LIMIT));
        prev_error_next = targ_c - meas_c;
        integ_sum = wspid_pkg::ACC_W'(integral_reg) + wspid_pkg::ACC_W'(prev_error_next);
        integral_next = wspid_pkg::INTEG_W'(wspid_pkg::sat(integ_sum,
                                                           wspid_pkg::INTEGRAL_LIMIT));
        deriv_next = prev_error_next - prev_error_reg;
    end

    // State advances only when a beat moves into this stage, so the held
    // values always belong to the item sitting here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            integral_reg   <= '0;
        end
        else if (load)
        begin
            prev_error_reg <= prev_error_next;
            integral_reg   <= integral_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            deriv_reg <= deriv_next;
    end

    assign terms.err      = prev_error_reg;
    assign terms.integral = integral_reg;
    assign terms.deriv    = deriv_reg;

endmodule

[rtl/core/wheel_speed_pid_antiwindup_core.sv]
// Top level of the wheel speed PID core with integral clamp and output saturation.
// Depends on wspid_pkg, the three channel interfaces and wspid_err_stage.
//
//  channel | dir | payload                     | accepted when
//  sample  | in  | measured, setpoint (s16)    | sample.valid & sample.ready
//  result  | out | drive (s15)                 | result.valid & result.ready
//  cfg     | in  | index (2b), data (s16 gain) | cfg.valid & cfg.ready
//
// Four register stages: input, error/integral, products, drive. Result valid
// rises when the sample reaches the drive stage, and one sample per cycle is
// sustained while the result is not stalled. The error stage closes the
// integral and previous-error loop from its own registers. A stalled result
// holds only the stages behind it that are full, so empty stages keep taking
// samples. Reset clears gains, loop state and valids. cfg is always ready;
// writes to an unused index are dropped.
module wheel_speed_pid_antiwindup_core (
    input  logic              clk,
    input  logic              rst_n,
    wspid_sample_if.sink      sample,
    wspid_result_if.source    result,
    wspid_cfg_if.sink         cfg
);

    wspid_pkg::gain_t prop_gain_reg;
    wspid_pkg::gain_t integ_gain_reg;
    wspid_pkg::gain_t deriv_gain_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    wspid_pkg::speed_t meas_reg;
    wspid_pkg::speed_t setp_reg;

    wspid_pkg::err_terms_t terms;

    wspid_pkg::prod_t pp_reg;
    wspid_pkg::prod_t pi_reg;
    wspid_pkg::prod_t pd_reg;
    wspid_pkg::prod_t pp_next;
    wspid_pkg::prod_t pi_next;
    wspid_pkg::prod_t pd_next;

    wspid_pkg::acc_t   acc;
    wspid_pkg::acc_t   shifted;
    wspid_pkg::drive_t drive_reg;
    wspid_pkg::drive_t drive_next;

    // Each stage may load when it is empty or the stage ahead takes its beat
    assign rdy4 = !v4_reg || result.ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign sample.ready = rdy1;
    assign cfg.ready    = 1'b1;

    // Gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                wspid_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg.data;
                wspid_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg.data;
                wspid_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg.data;
                default:                   ;
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= sample.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (rdy1 && sample.valid)
        begin
            meas_reg <= sample.measured;
            setp_reg <= sample.setpoint;
        end
    end

    wspid_err_stage u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (rdy2 && v1_reg),
        .measured (meas_reg),
        .setpoint (setp_reg),
        .terms    (terms)
    );

    // Product stage
    always_comb
    begin
        pp_next = wspid_pkg::PROD_W'(prop_gain_reg)  * wspid_pkg::PROD_W'(terms.err);
        pi_next = wspid_pkg::PROD_W'(integ_gain_reg) * wspid_pkg::PROD_W'(terms.integral);
        pd_next = wspid_pkg::PROD_W'(deriv_gain_reg) * wspid_pkg::PROD_W'(terms.deriv);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            pp_reg <= pp_next;
            pi_reg <= pi_next;
            pd_reg <= pd_next;
        end
    end

    // Sum, drop the gain fraction (floor), saturate
    always_comb
    begin
        acc = wspid_pkg::ACC_W'(pp_reg) + wspid_pkg::ACC_W'(pi_reg)
            + wspid_pkg::ACC_W'(pd_reg);
        shifted = acc >>> wspid_pkg::FRAC_BITS;
        drive_next = wspid_pkg::DRIVE_W'(wspid_pkg::sat(shifted, wspid_pkg::OUTPUT_LIMIT));
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
            drive_reg <= drive_next;
    end

    assign result.valid = v4_reg;
    assign result.drive = drive_reg;

endmodule
